/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// KMM_ASSERT checks a property on every rising edge outside reset.
// KMM_ASSERT_NEXT checks that a condition leads to another one on the next edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KMM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define KMM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KMM_ASSERT(lbl, clk, rst, prop, msg)
`define KMM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/kmm_pkg.sv */
package kmm_pkg;

   // default sizes
   localparam int DEF_MAX_LISTS = 8;
   localparam int DEF_MAX_LEN   = 1024;

   // field widths
   localparam int KIND_W = 2;
   localparam int IDX_W  = 3;
   localparam int ID_W   = 31;
   localparam int CFG_W  = 4;
   localparam int MASK_W = 8;
   localparam int CNT_W  = 14;

   // reserved id marking an exhausted list
   localparam logic [ID_W-1:0] EXHAUSTED = '1;

   // item kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD  = 2'd0,
      KIND_NEXT  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_MIN,
      ST_EMIT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic clear;
      logic start;
      logic find;
      logic emit;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic merging;
      logic rsp_busy;
   } sts_type;

endpackage

/* hw/rtl/kway_merge_membership_mask.sv */
// K-way merge of ascending posting lists with a membership mask. Load items
// append an id to a list and clear items empty every list; both give no
// result. A next item yields the smallest head among the first
// num_lists lists, with a mask of the lists that held it, and steps those lists
// on; once all are exhausted it yields a closing result (is_last) with the
// loaded total, the merged count and their difference, and a further next
// item starts over. A next item passes through accept, minimum search and
// emit, with a head fill step after accept when it starts a merge, as each
// list's first id must come out of its memory first; the refill reads of the
// per-list memories overlap the following accept. Each list has its own
// MAX_LEN-deep id memory, so all lists refill in parallel. A result waits in
// an output register while the next item is taken; an emit waits only while
// that register is still held. Loads are ignored during a merge, into a full
// list, and for id 0x7fffffff. The id memories need no clearing after reset.
module kway_merge_membership_mask #(
   parameter int MAX_LISTS = kmm_pkg::DEF_MAX_LISTS,
   parameter int MAX_LEN   = kmm_pkg::DEF_MAX_LEN
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [kmm_pkg::CFG_W-1:0]    csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [kmm_pkg::KIND_W-1:0]   req_kind,
   input  logic [kmm_pkg::IDX_W-1:0]    req_list_index,
   input  logic [kmm_pkg::ID_W-1:0]     req_doc_id,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [kmm_pkg::ID_W-1:0]     rsp_merged_id,
   output logic [kmm_pkg::MASK_W-1:0]   rsp_membership,
   output logic                         rsp_is_last,
   output logic [kmm_pkg::CNT_W-1:0]    rsp_total_before,
   output logic [kmm_pkg::CNT_W-1:0]    rsp_total_after,
   output logic [kmm_pkg::CNT_W-1:0]    rsp_saving
);

   kmm_pkg::cmd_type cmd;
   kmm_pkg::sts_type sts;

   // sequencer
   kmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // lists, heads and result register
   kmm_datapath #(
      .MAX_LISTS (MAX_LISTS),
      .MAX_LEN   (MAX_LEN)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_list_index   (req_list_index),
      .req_doc_id       (req_doc_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged_id    (rsp_merged_id),
      .rsp_membership   (rsp_membership),
      .rsp_is_last      (rsp_is_last),
      .rsp_total_before (rsp_total_before),
      .rsp_total_after  (rsp_total_after),
      .rsp_saving       (rsp_saving)
   );

endmodule

/* hw/rtl/kmm_ram.sv */
module kmm_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/kmm_ctrl.sv */
`include "assert_macros.svh"

module kmm_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kmm_pkg::KIND_W-1:0]        req_kind,
   input  logic                              rsp_stall,
   input  kmm_pkg::sts_type                  sts,
   output kmm_pkg::cmd_type                  cmd
);

   kmm_pkg::state_type state_ff, state_in;
   logic               slot_free;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register free, or emptied this cycle
   assign slot_free = !sts.rsp_busy || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         kmm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (req_kind)
                  kmm_pkg::KIND_LOAD: begin
                     cmd.load = 1'b1;
                  end
                  kmm_pkg::KIND_NEXT: begin
                     if (sts.merging) begin
                        state_in = kmm_pkg::ST_MIN;
                     end else begin
                        cmd.start = 1'b1;
                        state_in  = kmm_pkg::ST_FILL;
                     end
                  end
                  kmm_pkg::KIND_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         kmm_pkg::ST_FILL: begin
            state_in = kmm_pkg::ST_MIN;
         end
         kmm_pkg::ST_MIN: begin
            cmd.find = 1'b1;
            state_in = kmm_pkg::ST_EMIT;
         end
         kmm_pkg::ST_EMIT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = kmm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kmm_pkg::ST_IDLE;
         end
      endcase
   end

   // checks
   `KMM_ASSERT(a_cmd_single, clock, reset, $onehot0(cmd), "more than one command at once")
   `KMM_ASSERT(a_fill_after_start, clock, reset, (state_ff == kmm_pkg::ST_FILL) |-> $past(cmd.start), "head fill without a merge start")

endmodule

/* hw/rtl/kmm_datapath.sv */
`include "assert_macros.svh"

module kmm_datapath #(
   parameter int MAX_LISTS = kmm_pkg::DEF_MAX_LISTS,
   parameter int MAX_LEN   = kmm_pkg::DEF_MAX_LEN
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kmm_pkg::cmd_type              cmd,
   output kmm_pkg::sts_type              sts,
   input  logic                          csr_wr_en,
   input  logic [kmm_pkg::CFG_W-1:0]     csr_wr_data,
   input  logic [kmm_pkg::IDX_W-1:0]     req_list_index,
   input  logic [kmm_pkg::ID_W-1:0]      req_doc_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [kmm_pkg::ID_W-1:0]      rsp_merged_id,
   output logic [kmm_pkg::MASK_W-1:0]    rsp_membership,
   output logic                          rsp_is_last,
   output logic [kmm_pkg::CNT_W-1:0]     rsp_total_before,
   output logic [kmm_pkg::CNT_W-1:0]     rsp_total_after,
   output logic [kmm_pkg::CNT_W-1:0]     rsp_saving
);

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int NUM_W  = kmm_pkg::CFG_W + 1;
   localparam int MW     = (MAX_LISTS > kmm_pkg::MASK_W) ? MAX_LISTS : kmm_pkg::MASK_W;
   localparam int ID_W   = kmm_pkg::ID_W;
   localparam int CNT_W  = kmm_pkg::CNT_W;

   // per-list state
   logic [LEN_W-1:0]  len_ff    [MAX_LISTS];
   logic [LEN_W-1:0]  len_in    [MAX_LISTS];
   logic [LEN_W-1:0]  cursor_ff [MAX_LISTS];
   logic [LEN_W-1:0]  cursor_in [MAX_LISTS];
   logic [ID_W-1:0]   head_ff   [MAX_LISTS];
   logic [ID_W-1:0]   head_in   [MAX_LISTS];
   logic [MAX_LISTS-1:0] fetch_ff, fetch_in;

   // merge state
   logic              merging_ff, merging_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  before_ff, before_in;
   logic [ID_W-1:0]   min_ff, min_in;
   logic [kmm_pkg::CFG_W-1:0] cfg_ff, cfg_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]            rsp_id_ff, rsp_id_in;
   logic [kmm_pkg::MASK_W-1:0] rsp_mask_ff, rsp_mask_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]           rsp_before_ff, rsp_before_in;
   logic [CNT_W-1:0]           rsp_after_ff, rsp_after_in;
   logic [CNT_W-1:0]           rsp_saving_ff, rsp_saving_in;

   // list memories
   logic [MAX_LISTS-1:0] ram_we, ram_re;
   logic [ADDR_W-1:0]    ram_waddr [MAX_LISTS];
   logic [ADDR_W-1:0]    ram_raddr [MAX_LISTS];
   logic [ID_W-1:0]      ram_rdata [MAX_LISTS];

   // scratch
   logic [NUM_W-1:0]     n_eff;
   logic [MAX_LISTS-1:0] active;
   logic [ID_W-1:0]      min_v;
   logic [CNT_W-1:0]     sum_v;
   logic [MW-1:0]        mask_v;

   // one memory per list, so all lists refill in the same cycle
   for (genvar g = 0; g < MAX_LISTS; g++) begin : g_list
      kmm_ram #(
         .WIDTH (ID_W),
         .DEPTH (MAX_LEN)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_we[g]),
         .wr_addr (ram_waddr[g]),
         .wr_data (req_doc_id),
         .rd_en   (ram_re[g]),
         .rd_addr (ram_raddr[g]),
         .rd_data (ram_rdata[g])
      );
   end

   // lists in the merge: zero acts as one, clamp at the list count
   always_comb begin
      if (cfg_ff == '0) begin
         n_eff = NUM_W'(1);
      end else if ({1'b0, cfg_ff} > NUM_W'(MAX_LISTS)) begin
         n_eff = NUM_W'(MAX_LISTS);
      end else begin
         n_eff = {1'b0, cfg_ff};
      end
      for (int k = 0; k < MAX_LISTS; k++) begin
         active[k] = NUM_W'(k) < n_eff;
      end
   end

   // smallest head and length total over the lists in the merge
   always_comb begin
      min_v = kmm_pkg::EXHAUSTED;
      sum_v = '0;
      for (int k = 0; k < MAX_LISTS; k++) begin
         if (active[k] && head_ff[k] < min_v) begin
            min_v = head_ff[k];
         end
         if (active[k]) begin
            sum_v = sum_v + CNT_W'(len_ff[k]);
         end
      end
   end

   // datapath next values
   always_comb begin
      len_in        = len_ff;
      cursor_in     = cursor_ff;
      head_in       = head_ff;
      fetch_in      = '0;
      merging_in    = merging_ff;
      count_in      = count_ff;
      before_in     = before_ff;
      min_in        = min_ff;
      cfg_in        = cfg_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_before_in = rsp_before_ff;
      rsp_after_in  = rsp_after_ff;
      rsp_saving_in = rsp_saving_ff;
      rsp_valid_in  = rsp_stall ? rsp_valid_ff : 1'b0;
      ram_we        = '0;
      ram_re        = '0;
      mask_v        = '0;
      for (int k = 0; k < MAX_LISTS; k++) begin
         ram_waddr[k] = len_ff[k][ADDR_W-1:0];
         ram_raddr[k] = cursor_ff[k][ADDR_W-1:0];
      end

      if (csr_wr_en) begin
         cfg_in = csr_wr_data;
      end

      // heads read in the previous cycle land now
      for (int k = 0; k < MAX_LISTS; k++) begin
         if (fetch_ff[k]) begin
            head_in[k] = ram_rdata[k];
         end
      end

      // append; dropped while merging, into a full list or for the marker id
      if (cmd.load && !merging_ff && req_doc_id != kmm_pkg::EXHAUSTED) begin
         for (int k = 0; k < MAX_LISTS; k++) begin
            if (int'(req_list_index) == k && len_ff[k] < LEN_W'(MAX_LEN)) begin
               ram_we[k] = 1'b1;
               len_in[k] = len_ff[k] + LEN_W'(1);
            end
         end
      end

      // merge start: read the first id of every non-empty list
      if (cmd.start) begin
         merging_in = 1'b1;
         count_in   = '0;
         for (int k = 0; k < MAX_LISTS; k++) begin
            ram_raddr[k] = '0;
            if (len_ff[k] != '0) begin
               ram_re[k]    = 1'b1;
               fetch_in[k]  = 1'b1;
               cursor_in[k] = LEN_W'(1);
            end else begin
               cursor_in[k] = '0;
               head_in[k]   = kmm_pkg::EXHAUSTED;
            end
         end
      end

      if (cmd.find) begin
         min_in    = min_v;
         before_in = sum_v;
      end

      // result, and advance of every list in the merge that held the minimum
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (min_ff == kmm_pkg::EXHAUSTED) begin
            rsp_id_in     = '0;
            rsp_mask_in   = '0;
            rsp_last_in   = 1'b1;
            rsp_before_in = before_ff;
            rsp_after_in  = count_ff;
            rsp_saving_in = before_ff - count_ff;
            merging_in    = 1'b0;
         end else begin
            for (int k = 0; k < MAX_LISTS; k++) begin
               if (active[k] && head_ff[k] == min_ff) begin
                  mask_v[k] = 1'b1;
                  if (cursor_ff[k] < len_ff[k]) begin
                     ram_re[k]    = 1'b1;
                     fetch_in[k]  = 1'b1;
                     cursor_in[k] = cursor_ff[k] + LEN_W'(1);
                  end else begin
                     head_in[k] = kmm_pkg::EXHAUSTED;
                  end
               end
            end
            count_in      = count_ff + CNT_W'(1);
            rsp_id_in     = min_ff;
            rsp_mask_in   = mask_v[kmm_pkg::MASK_W-1:0];
            rsp_last_in   = 1'b0;
            rsp_before_in = '0;
            rsp_after_in  = '0;
            rsp_saving_in = '0;
         end
      end

      // clear empties every list and ends any merge
      if (cmd.clear) begin
         for (int k = 0; k < MAX_LISTS; k++) begin
            len_in[k]    = '0;
            cursor_in[k] = '0;
            head_in[k]   = kmm_pkg::EXHAUSTED;
         end
         fetch_in   = '0;
         count_in   = '0;
         merging_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_LISTS; k++) begin
            len_ff[k]    <= '0;
            cursor_ff[k] <= '0;
            head_ff[k]   <= kmm_pkg::EXHAUSTED;
         end
         fetch_ff     <= '0;
         merging_ff   <= 1'b0;
         count_ff     <= '0;
         cfg_ff       <= kmm_pkg::CFG_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         cursor_ff    <= cursor_in;
         head_ff      <= head_in;
         fetch_ff     <= fetch_in;
         merging_ff   <= merging_in;
         count_ff     <= count_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      min_ff        <= min_in;
      before_ff     <= before_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_before_ff <= rsp_before_in;
      rsp_after_ff  <= rsp_after_in;
      rsp_saving_ff <= rsp_saving_in;
   end

   assign sts.merging      = merging_ff;
   assign sts.rsp_busy     = rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_id    = rsp_id_ff;
   assign rsp_membership   = rsp_mask_ff;
   assign rsp_is_last      = rsp_last_ff;
   assign rsp_total_before = rsp_before_ff;
   assign rsp_total_after  = rsp_after_ff;
   assign rsp_saving       = rsp_saving_ff;

   // checks
   `KMM_ASSERT(a_find_in_merge, clock, reset, cmd.find |-> merging_ff, "minimum taken outside a merge")
   `KMM_ASSERT(a_merge_rise, clock, reset, $rose(merging_ff) |-> $past(cmd.start), "merge began without a start")
   `KMM_ASSERT(a_fetch_in_merge, clock, reset, (fetch_ff != '0) |-> merging_ff, "head refill outside a merge")
   `KMM_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_valid_ff, "emitted result not presented")

endmodule
